// ===== sv/bpfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bpfr_pkg
// Shared constants, codes and beat types of the bit pattern find/replace block.
// ----------------------------------------------------------------------------
package bpfr_pkg;

  localparam int unsigned PatternMax = 16;
  localparam int unsigned ReplaceMax = 32;

  localparam int unsigned PatField = 16;
  localparam int unsigned RepField = 32;
  localparam int unsigned RepLenW  = 6;
  localparam int unsigned PatLenW  = 5;
  localparam int unsigned PosW     = 32;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  localparam int unsigned RunW = (ReplaceMax > PatternMax) ? ReplaceMax : PatternMax;
  localparam int unsigned LenW = $clog2(PatternMax + 1);
  localparam int unsigned IdxW = (PatternMax > 1) ? $clog2(PatternMax) : 1;

  typedef enum logic [1:0] {
    KindData = 2'd0,
    KindPos  = 2'd1,
    KindEnd  = 2'd2
  } kind_e;

  typedef enum logic [AddrW-3:0] {
    RegMode    = 3'd0,
    RegPatBits = 3'd1,
    RegPatLen  = 3'd2,
    RegRepBits = 3'd3,
    RegRepLen  = 3'd4
  } reg_e;

  typedef struct packed {
    logic in_bit;
    logic end_of_stream;
  } in_beat_t;

  typedef struct packed {
    kind_e            kind;
    logic             out_bit;
    logic [PosW-1:0]  match_position;
    logic             run_last;
  } out_beat_t;

  typedef struct packed {
    logic vld;
    logic dat;
  } cell_tap_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic [RunW-1:0] run_bits;
    logic [RunW-1:0] run_vld;
    logic            pos_vld;
    logic [PosW-1:0] pos;
    logic            fin;
  } job_t;

endpackage

// ===== sv/bit_pattern_find_replace.sv =====
// ----------------------------------------------------------------------------
// bit_pattern_find_replace
// Streams one bit per input beat against a configured pattern of 1 to 16 bits.
//
// Input beats carry in_bit and end_of_stream; output beats carry kind (data
// bit, match position or end marker), out_bit, match_position and run_last,
// which marks the final result caused by one input beat. Registers are to
// be written over the APB port only while the block is idle; the block
// itself does not enforce this. Each input beat is taken by a row of window
// cells; its results pass through the sequencer's job register to the
// output register, one per cycle while the receiver does not stall. A beat
// with zero or one result admits the next beat as it hands that result on,
// so plain find and unmatched replace traffic run at one beat per cycle
// while the receiver does not stall; a beat with more results (replacement
// run, window flush on end_of_stream) holds the input until all are sent.
// When the receiver stalls, the output register holds its beat and the
// sequencer keeps the results of at most one more input beat; the input
// waits until the sequencer has handed them on.
// Reset clears the window, the bit counter and the registers to their
// defaults (replace mode, pattern length one); no further setup time.
// ----------------------------------------------------------------------------
module bit_pattern_find_replace
  import bpfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_beat_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_beat_t        out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic                mode_q;
  logic [PatField-1:0] pattern_bits_q;
  logic [PatLenW-1:0]  pattern_length_q;
  logic [RepField-1:0] repl_bits_q;
  logic [RepLenW-1:0]  repl_len_q;
  logic [PosW-1:0]     bits_seen_q, bits_seen_d;

  logic                cfg_wr, cfg_clear;
  reg_e                cfg_reg;
  logic [LenW-1:0]     l_eff, l_m1;
  logic [IdxW-1:0]     l_idx;
  logic [RepLenW-1:0]  rl_eff;
  logic                accept, last, cmp, hit;
  cell_ctrl_t          ctrl;
  cell_tap_t           tap [PatternMax];
  logic [PatternMax-1:0] ins_vld, ins_dat, win_vld, match, pat_en;
  logic [PatternMax-1:0] pat_ext;
  job_t                job;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_reg = reg_e'(paddr[AddrW-1:2]);
  assign cfg_clear = cfg_wr & ((cfg_reg == RegMode) | (cfg_reg == RegPatLen));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q           <= 1'b0;
      pattern_bits_q   <= '0;
      pattern_length_q <= PatLenW'(1);
      repl_bits_q      <= '0;
      repl_len_q       <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg)
        RegMode:    mode_q           <= pwdata[0];
        RegPatBits: pattern_bits_q   <= pwdata[PatField-1:0];
        RegPatLen:  pattern_length_q <= pwdata[PatLenW-1:0];
        RegRepBits: repl_bits_q      <= pwdata[RepField-1:0];
        RegRepLen:  repl_len_q       <= pwdata[RepLenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      RegMode:    prdata = DataW'(mode_q);
      RegPatBits: prdata = DataW'(pattern_bits_q);
      RegPatLen:  prdata = DataW'(pattern_length_q);
      RegRepBits: prdata = DataW'(repl_bits_q);
      RegRepLen:  prdata = DataW'(repl_len_q);
      default:    prdata = '0;
    endcase
  end

  // effective lengths
  always_comb begin
    if (pattern_length_q == '0) begin
      l_eff = LenW'(1);
    end else if (pattern_length_q > PatternMax) begin
      l_eff = LenW'(PatternMax);
    end else begin
      l_eff = LenW'(pattern_length_q);
    end
    if (repl_len_q > ReplaceMax) begin
      rl_eff = RepLenW'(ReplaceMax);
    end else begin
      rl_eff = repl_len_q;
    end
  end

  assign l_m1    = l_eff - LenW'(1);
  assign l_idx   = IdxW'(l_m1);
  assign pat_ext = PatternMax'({{PatternMax{1'b0}}, pattern_bits_q});

  // window cells
  assign accept = in_valid_i & in_ready_o;
  assign last   = in_data_i.end_of_stream;
  assign cmp    = ins_vld[l_idx];
  assign hit    = cmp & (&match);

  assign ctrl.load  = accept;
  assign ctrl.clear = cfg_clear | (accept & (last | (hit & ~mode_q)));
  assign ctrl.shift = cmp;

  for (genvar k = 0; k < PatternMax; k++) begin : g_cell
    logic      prev_vld;
    cell_tap_t right;

    if (k == 0) begin : g_first
      assign prev_vld = 1'b1;
    end else begin : g_next
      assign prev_vld = win_vld[k-1];
    end

    if (k == PatternMax - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = tap[k+1];
    end

    assign pat_en[k]  = (LenW'(k) < l_eff);
    assign ins_vld[k] = tap[k].vld;
    assign ins_dat[k] = tap[k].dat;

    bpfr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_bit_i   (in_data_i.in_bit),
      .prev_vld_i (prev_vld),
      .right_i    (right),
      .ctrl_i     (ctrl),
      .pat_bit_i  (pat_ext[k]),
      .pat_en_i   (pat_en[k]),
      .tap_o      (tap[k]),
      .vld_o      (win_vld[k]),
      .match_o    (match[k])
    );
  end

  // bit position counter
  always_comb begin
    bits_seen_d = bits_seen_q;
    if (accept) begin
      if (last) begin
        bits_seen_d = '0;
      end else if (bits_seen_q != '1) begin
        bits_seen_d = bits_seen_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_seen_q <= '0;
    end else begin
      bits_seen_q <= bits_seen_d;
    end
  end

  // results of the current beat
  always_comb begin
    job.pos_vld = mode_q & hit;
    job.pos     = bits_seen_q - PosW'(l_m1);
    job.fin     = last;
    job.run_vld = '0;
    if (!mode_q && hit) begin
      job.run_bits = RunW'({{RunW{1'b0}}, repl_bits_q});
      for (int k = 0; k < RunW; k++) begin
        job.run_vld[k] = (k < rl_eff);
      end
    end else begin
      job.run_bits = RunW'({{RunW{1'b0}}, ins_dat});
      if (!mode_q) begin
        if (last) begin
          job.run_vld = RunW'({{RunW{1'b0}}, ins_vld});
        end else begin
          job.run_vld[0] = cmp;
        end
      end
    end
  end

  bpfr_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .job_i       (job),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // the window never holds a full pattern between beats
  assert property (@(posedge clk_i) disable iff (!rst_ni) !win_vld[l_idx])
    else $error("window holds a full pattern length");

  // end of stream empties the window and restarts the position count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> (win_vld == '0) && (bits_seen_q == '0))
    else $error("window or position not cleared after end of stream");

  // find mode gives no data bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KindData) |-> !mode_q)
    else $error("data beat in find mode");

  // an end marker always closes the results of its beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KindEnd) |-> out_data_o.run_last)
    else $error("end marker without run_last");

endmodule

// ===== sv/bpfr_cell.sv =====
// ----------------------------------------------------------------------------
// bpfr_cell
// One window cell: holds one pending stream bit, takes the incoming bit when
// it is the first empty slot, compares against its pattern bit and hands its
// bit to the left neighbor on a shift.
// ----------------------------------------------------------------------------
module bpfr_cell
  import bpfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_bit_i,
  input  logic       prev_vld_i,
  input  cell_tap_t  right_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       pat_bit_i,
  input  logic       pat_en_i,
  output cell_tap_t  tap_o,
  output logic       vld_o,
  output logic       match_o
);

  logic vld_q, vld_d;
  logic dat_q, dat_d;

  assign tap_o.vld = vld_q | prev_vld_i;
  assign tap_o.dat = vld_q ? dat_q : (prev_vld_i & in_bit_i);
  assign match_o   = ~pat_en_i | (tap_o.dat == pat_bit_i);
  assign vld_o     = vld_q;

  always_comb begin
    vld_d = vld_q;
    dat_d = dat_q;
    if (ctrl_i.clear) begin
      vld_d = 1'b0;
    end else if (ctrl_i.load) begin
      if (ctrl_i.shift) begin
        vld_d = right_i.vld;
        dat_d = right_i.dat;
      end else begin
        vld_d = tap_o.vld;
        dat_d = tap_o.dat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dat_q <= dat_d;
  end

endmodule

// ===== sv/bpfr_emit.sv =====
// ----------------------------------------------------------------------------
// bpfr_emit
// Result sequencer: holds the results of one item (data run, match position,
// end marker); hands them one per cycle to the output register unless stalled.
// ----------------------------------------------------------------------------
module bpfr_emit
  import bpfr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  job_t      job_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  job_t      job_q, job_d;
  logic      out_valid_q, out_valid_d;
  out_beat_t out_q, out_d;
  out_beat_t head;
  logic      has_run, busy, out_adv, take;

  assign has_run = job_q.run_vld[0];
  assign busy    = has_run | job_q.pos_vld | job_q.fin;
  assign out_adv = ~out_valid_q | out_ready_i;
  assign take    = out_adv & busy;
  assign ready_o = ~busy | (take & head.run_last);

  always_comb begin
    head = '{kind: KindEnd, out_bit: 1'b0, match_position: '0, run_last: 1'b1};
    if (has_run) begin
      head.kind     = KindData;
      head.out_bit  = job_q.run_bits[0];
      head.run_last = ~(job_q.run_vld[1] | job_q.pos_vld | job_q.fin);
    end else if (job_q.pos_vld) begin
      head.kind           = KindPos;
      head.match_position = job_q.pos;
      head.run_last       = ~job_q.fin;
    end
  end

  always_comb begin
    job_d = job_q;
    if (accept_i) begin
      job_d = job_i;
    end else if (take) begin
      if (has_run) begin
        job_d.run_bits = job_q.run_bits >> 1;
        job_d.run_vld  = job_q.run_vld >> 1;
      end else if (job_q.pos_vld) begin
        job_d.pos_vld = 1'b0;
      end else begin
        job_d.fin = 1'b0;
      end
    end
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_adv) begin
      out_valid_d = busy;
      out_d       = head;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      job_q       <= job_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bit pattern find/replace block. Bits go in one
// beat at a time over a valid/ready channel with random bursts and gaps; a
// behavioral scan of the window predicts every output beat, and each beat the
// block delivers is compared field by field with the oldest prediction. The
// APB port sets mode, pattern and replacement between streams, including the
// clamped lengths and writes that land in the middle of a stream.
// ----------------------------------------------------------------------------
module tb;
  import bpfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  in_beat_t         in_data_i;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_beat_t        out_data_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  bit_pattern_find_replace dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the register file
  logic              cfg_mode = 1'b0;
  logic [PatField-1:0] cfg_pat = '0;
  logic [PatLenW-1:0]  cfg_plen = 5'd1;
  logic [RepField-1:0] cfg_rep = '0;
  logic [RepLenW-1:0]  cfg_rlen = '0;

  // scan state
  logic [31:0] scan_window = '0;
  int unsigned scan_fill = 0;
  logic [31:0] bit_index = '0;

  out_beat_t pending_results_q[$];

  int unsigned n_errors = 0;
  int unsigned n_beats_in = 0;
  int unsigned n_beats_out = 0;
  int unsigned n_reg_writes = 0;

  int unsigned gap_pct = 0;
  int unsigned burst_left = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_epoch = 0;

  function automatic int unsigned eff_pat_len();
    int unsigned l;
    l = cfg_plen;
    if (l == 0) l = 1;
    if (l > PatternMax) l = PatternMax;
    return l;
  endfunction

  task automatic push_result(input kind_e k, input logic b, input logic [PosW-1:0] pos);
    out_beat_t r;
    r.kind = k;
    r.out_bit = b;
    r.match_position = pos;
    r.run_last = 1'b0;
    pending_results_q.insert(pending_results_q.size(), r);
  endtask

  task automatic scan_bit(input in_beat_t b);
    int unsigned l;
    int unsigned rl;
    int unsigned n;
    logic [31:0] mask;
    logic hit;
    l = eff_pat_len();
    mask = (32'd1 << l) - 32'd1;
    n = 0;
    if (scan_fill >= PatternMax) begin
      scan_window = '0;
      scan_fill = 0;
    end
    scan_window = scan_window | (32'(b.in_bit) << scan_fill);
    scan_fill++;
    if (scan_fill >= l) begin
      hit = ((scan_window ^ 32'(cfg_pat)) & mask) == 32'd0;
      if (cfg_mode) begin
        if (hit) begin
          push_result(KindPos, 1'b0, bit_index - 32'(l - 1));
          n++;
        end
        scan_window = scan_window >> 1;
        scan_fill--;
      end else if (hit) begin
        rl = (cfg_rlen > ReplaceMax) ? ReplaceMax : cfg_rlen;
        for (int i = 0; i < rl; i++) push_result(KindData, cfg_rep[i], '0);
        n += rl;
        scan_window = scan_window >> l;
        scan_fill -= l;
      end else begin
        push_result(KindData, scan_window[0], '0);
        n++;
        scan_window = scan_window >> 1;
        scan_fill--;
      end
    end
    if (bit_index != 32'hFFFF_FFFF) bit_index++;
    if (b.end_of_stream) begin
      if (!cfg_mode) begin
        for (int i = 0; i < scan_fill; i++) push_result(KindData, scan_window[i], '0);
        n += scan_fill;
      end
      push_result(KindEnd, 1'b0, '0);
      n++;
      scan_window = '0;
      scan_fill = 0;
      bit_index = '0;
    end
    if (n > 0) begin
      pending_results_q[pending_results_q.size() - 1].run_last = 1'b1;
    end
  endtask

  task automatic check_result(input out_beat_t act);
    out_beat_t exp;
    n_beats_out++;
    if (pending_results_q.size() == 0) begin
      $error("unexpected result beat: kind %0d bit %0d pos %0d", act.kind, act.out_bit,
             act.match_position);
      n_errors++;
    end else begin
      exp = pending_results_q.pop_front();
      if (act.kind !== exp.kind) begin
        $error("kind: expected %0d, actual %0d", exp.kind, act.kind);
        n_errors++;
      end
      if (act.out_bit !== exp.out_bit) begin
        $error("out_bit: expected %0d, actual %0d", exp.out_bit, act.out_bit);
        n_errors++;
      end
      if (act.match_position !== exp.match_position) begin
        $error("match_position: expected %0d, actual %0d", exp.match_position,
               act.match_position);
        n_errors++;
      end
      if (act.run_last !== exp.run_last) begin
        $error("run_last: expected %0d, actual %0d", exp.run_last, act.run_last);
        n_errors++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        scan_bit(in_data_i);
        n_beats_in++;
      end
      if (out_valid_o && out_ready_i) check_result(out_data_o);
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (stall_epoch == 0) begin
      stall_epoch = $urandom_range(20, 80);
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end else begin
      stall_epoch--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_beat(input logic bitv, input logic eos);
    in_beat_t b;
    b.in_bit = bitv;
    b.end_of_stream = eos;
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(99) < gap_pct) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_stream(input logic [63:0] bits, input int unsigned n, input logic eos);
    for (int i = 0; i < n; i++) send_beat(bits[i], eos && (i == n - 1));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e r, input logic [DataW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (r)
      RegMode: begin
        cfg_mode = val[0];
        scan_window = '0;
        scan_fill = 0;
      end
      RegPatBits: cfg_pat = val[PatField-1:0];
      RegPatLen: begin
        cfg_plen = val[PatLenW-1:0];
        scan_window = '0;
        scan_fill = 0;
      end
      RegRepBits: cfg_rep = val[RepField-1:0];
      RegRepLen: cfg_rlen = val[RepLenW-1:0];
      default: ;
    endcase
    n_reg_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // defaults: pattern '0' of length one, empty replacement deletes zeros
  task automatic test_reset_defaults();
    gap_pct = 0;
    send_stream(64'b1001, 4, 1'b1);
    wait_drain();
  endtask

  task automatic test_replace_directed();
    gap_pct = 50;
    write_reg(RegMode, 32'd0);
    write_reg(RegPatBits, 32'h0000_000D);
    write_reg(RegPatLen, 32'd4);
    write_reg(RegRepBits, 32'h0000_00A5);
    write_reg(RegRepLen, 32'd8);
    // one match, then the pending bits of an unfilled window flushed on end
    send_stream(64'b110_1101, 7, 1'b1);
    wait_drain();
    // pending bits dropped by a length write mid stream
    send_stream(64'b01, 2, 1'b0);
    wait_drain();
    write_reg(RegPatLen, 32'd0);
    write_reg(RegRepBits, 32'hFFFF_FFFF);
    write_reg(RegRepLen, 32'd63);
    send_stream(64'b1, 1, 1'b1);
    wait_drain();
    write_reg(RegRepLen, 32'd0);
    send_stream(64'b01, 2, 1'b1);
    wait_drain();
  endtask

  task automatic test_find_directed();
    gap_pct = 0;
    write_reg(RegPatBits, 32'h0000_FFFF);
    write_reg(RegPatLen, 32'd2);
    send_stream(64'b1, 1, 1'b0);
    wait_drain();
    // mode write drops the pending bit but keeps the bit count
    write_reg(RegMode, 32'd1);
    send_stream(64'b1111, 4, 1'b1);
    wait_drain();
  endtask

  task automatic test_backpressure();
    gap_pct = 0;
    write_reg(RegMode, 32'd0);
    write_reg(RegPatBits, 32'h0000_0001);
    write_reg(RegPatLen, 32'd1);
    write_reg(RegRepBits, $urandom);
    write_reg(RegRepLen, 32'd32);
    hold_req = 400;
    for (int i = 0; i < 24; i++) send_beat(1'b1, i == 23);
    wait_drain();
  endtask

  task automatic new_settings(input logic all_regs);
    logic [DataW-1:0] v;
    if (all_regs || $urandom_range(99) < 60) write_reg(RegMode, 32'($urandom_range(1)));
    if (all_regs || $urandom_range(99) < 60) begin
      case ($urandom_range(5))
        0: v = 32'h0000_0000;
        1: v = 32'h0000_FFFF;
        default: v = 32'($urandom_range(0, 65535));
      endcase
      write_reg(RegPatBits, v);
    end
    if (all_regs || $urandom_range(99) < 60) begin
      case ($urandom_range(9))
        0: v = 32'd0;
        1: v = 32'($urandom_range(17, 31));
        2: v = 32'd16;
        default: v = 32'($urandom_range(1, 6));
      endcase
      write_reg(RegPatLen, v);
    end
    if (all_regs || $urandom_range(99) < 60) begin
      case ($urandom_range(5))
        0: v = 32'h0000_0000;
        1: v = 32'hFFFF_FFFF;
        default: v = $urandom;
      endcase
      write_reg(RegRepBits, v);
    end
    if (all_regs || $urandom_range(99) < 60) begin
      case ($urandom_range(7))
        0: v = 32'd0;
        1: v = 32'd32;
        2: v = 32'($urandom_range(33, 63));
        default: v = 32'($urandom_range(1, 6));
      endcase
      write_reg(RegRepLen, v);
    end
  endtask

  // streams seeded with copies of the pattern, some of them corrupted
  task automatic test_random_streams(input int unsigned target);
    int unsigned sent;
    int unsigned len;
    int unsigned l;
    int unsigned flip;
    logic eos_end;
    logic stream_q[$];
    sent = 0;
    new_settings(1'b1);
    while (sent < target) begin
      case ($urandom_range(2))
        0: gap_pct = 0;
        1: gap_pct = 30;
        default: gap_pct = 70;
      endcase
      len = $urandom_range(1, 40);
      eos_end = ($urandom_range(3) != 0);
      stream_q.delete();
      l = eff_pat_len();
      while (stream_q.size() < len) begin
        if ($urandom_range(99) < 45) begin
          flip = ($urandom_range(9) == 0) ? $urandom_range(l - 1) : PatternMax;
          for (int i = 0; i < l; i++) begin
            stream_q.insert(stream_q.size(), cfg_pat[i] ^ (i == flip));
          end
        end else begin
          stream_q.insert(stream_q.size(), 1'($urandom_range(1)));
        end
      end
      foreach (stream_q[i]) send_beat(stream_q[i], eos_end && (i == stream_q.size() - 1));
      sent += stream_q.size();
      wait_drain();
      new_settings(1'b0);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_replace_directed();
    test_find_directed();
    test_backpressure();
    test_random_streams(300);
    wait_drain();
    if (pending_results_q.size() != 0) begin
      $error("%0d expected result beats never arrived", pending_results_q.size());
      n_errors++;
    end
    $display("covered %0d input beats and %0d result beats across %0d register writes",
             n_beats_in, n_beats_out, n_reg_writes);
    $display("find and replace modes, clamped lengths, mid-stream writes, receiver hold-off");
    if (n_errors == 0) begin
      $display("[bit_pattern_find_replace] OK");
    end else begin
      $display("[bit_pattern_find_replace] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[bit_pattern_find_replace] ERROR");
    $finish;
  end

endmodule
